/* rtl/core/swm_pkg.sv */
// Shared constants and the controller-to-datapath command bundle for the
// sliding window mean and standard deviation block. No dependencies.
`default_nettype none

package swm_pkg;

	// window and sample geometry
	localparam int MAX_WINDOW  = 256;
	localparam int SAMPLE_BITS = 16;
	localparam int PTR_W       = $clog2(MAX_WINDOW);
	localparam int CNT_W       = $clog2(MAX_WINDOW + 1);

	// port field widths
	localparam int SAMPLE_W = 16;
	localparam int MEAN_W   = 24;
	localparam int STD_W    = 23;
	localparam int CFG_W    = 9;
	localparam int CFG_IDX_W = 1;

	// fixed point scaling
	localparam int MEAN_FRAC = 8;
	localparam int VAR_SHIFT = 16;

	// running accumulators
	localparam int SUM_W = SAMPLE_BITS + PTR_W;
	localparam int SQ_W  = 2 * SAMPLE_BITS + PTR_W;
	localparam int SMP_SQ_W = 2 * SAMPLE_BITS;

	// variance numerator, n^2 divisor, scaled variance and root remainder
	localparam int PA_W   = CNT_W + SQ_W;
	localparam int VN_W   = 2 * SUM_W;
	localparam int DV_W   = 2 * CNT_W - 1;
	localparam int QV_W   = 2 * STD_W;
	localparam int RS_W   = STD_W + 2;
	localparam int STEP_W = $clog2(QV_W);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_READY     = 1'd1;

	// register reset values
	localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = 9'd256;
	localparam logic [CFG_W-1:0] MIN_READY_RST     = 9'd1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic square;
		logic update;
		logic mult;
		logic init;
		logic div_step;
		logic mean_step;
		logic sqrt_step;
		logic out_load;
	} swm_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/swm_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module swm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/swm_ctrl.sv */
// Sequencing controller: handshakes, step counting and datapath commands.
// Depends on swm_pkg.
`default_nettype none

module swm_ctrl
	import swm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output swm_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_INIT = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_SQRT = 3'd6;
	localparam logic [2:0] ST_DONE = 3'd7;

	logic [2:0]        state_q;
	logic [2:0]        state_nxt;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_nxt;
	logic              out_valid_q;
	logic              accept;
	logic              out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// next state and step count
	always_comb begin
		state_nxt = state_q;
		step_nxt  = step_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = ST_LOAD;
				end
			end
			ST_LOAD: state_nxt = ST_UPD;
			ST_UPD:  state_nxt = ST_MUL;
			ST_MUL:  state_nxt = ST_INIT;
			ST_INIT: begin
				state_nxt = ST_DIV;
				step_nxt  = '0;
			end
			ST_DIV: begin
				if (step_q == STEP_W'(QV_W - 1)) begin
					state_nxt = ST_SQRT;
					step_nxt  = '0;
				end else begin
					step_nxt = step_q + 1'b1;
				end
			end
			ST_SQRT: begin
				if (step_q == STEP_W'(STD_W - 1)) begin
					state_nxt = ST_DONE;
				end else begin
					step_nxt = step_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd           = '0;
		cmd.accept    = accept;
		cmd.square    = (state_q == ST_LOAD);
		cmd.update    = (state_q == ST_UPD);
		cmd.mult      = (state_q == ST_MUL);
		cmd.init      = (state_q == ST_INIT);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.mean_step = (state_q == ST_DIV) && (step_q < STEP_W'(MEAN_W));
		cmd.sqrt_step = (state_q == ST_SQRT);
		cmd.out_load  = (state_q == ST_DONE) && out_free;
	end

	// state registers and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			step_q  <= step_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/swm_dp.sv */
// Datapath: configuration registers, sample ring, running sums, the two
// shift-subtract dividers, the square root unit and the result registers.
// Depends on swm_pkg and swm_ram.
`default_nettype none

module swm_dp
	import swm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire swm_cmd_t             cmd,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic [SAMPLE_W-1:0]  sample,
	output logic      [MEAN_W-1:0]    mean_fx,
	output logic      [STD_W-1:0]     std_fx,
	output logic                      ready_res
);

	// configuration and window state
	logic [CFG_W-1:0] wlen_q;
	logic [CFG_W-1:0] minrdy_q;
	logic [PTR_W-1:0] wpos_q;
	logic [CNT_W-1:0] fill_q;
	logic [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]  sq_q;

	// per request working registers
	logic [SAMPLE_BITS-1:0] samp_q;
	logic                   evict_q;
	logic [SAMPLE_BITS-1:0] old_q;
	logic [SMP_SQ_W-1:0]    old_sq_q;
	logic [SMP_SQ_W-1:0]    new_sq_q;
	logic                   rdy_q;
	logic [PA_W-1:0]        prod_a_q;
	logic [VN_W-1:0]        prod_b_q;
	logic [DV_W-1:0]        n2_q;
	logic [DV_W-1:0]        rem_v_q;
	logic [QV_W-1:0]        dq_q;
	logic [CNT_W-1:0]       rem_m_q;
	logic [MEAN_W-1:0]      mq_q;
	logic [RS_W-1:0]        rem_s_q;
	logic [STD_W-1:0]       root_q;
	logic [MEAN_W-1:0]      mean_q;
	logic [STD_W-1:0]       std_q;
	logic                   ready_q;

	logic [CNT_W-1:0]       len_eff;
	logic [CNT_W:0]         rd_base;
	logic [PTR_W-1:0]       raddr;
	logic [SAMPLE_BITS-1:0] rdata;
	logic [SAMPLE_BITS-1:0] old_sel;
	logic [CNT_W-1:0]       fill_new;
	logic [VN_W-1:0]        var_num;
	logic [DV_W:0]          t_v;
	logic                   ge_v;
	logic [CNT_W:0]         t_m;
	logic                   ge_m;
	logic [RS_W+1:0]        t_s;
	logic [RS_W+1:0]        trial_s;
	logic                   ge_s;

	// effective window length, clamped to 1..MAX_WINDOW
	always_comb begin
		if (wlen_q == '0) begin
			len_eff = CNT_W'(1);
		end else if (wlen_q > CFG_W'(MAX_WINDOW)) begin
			len_eff = CNT_W'(MAX_WINDOW);
		end else begin
			len_eff = CNT_W'(wlen_q);
		end
	end

	// oldest entry sits fill_q places behind the write position
	always_comb begin
		if (fill_q > CNT_W'(wpos_q)) begin
			rd_base = (CNT_W+1)'(wpos_q) + (CNT_W+1)'(MAX_WINDOW) - (CNT_W+1)'(fill_q);
		end else begin
			rd_base = (CNT_W+1)'(wpos_q) - (CNT_W+1)'(fill_q);
		end
		raddr = rd_base[PTR_W-1:0];
	end

	swm_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (cmd.update),
		.waddr(wpos_q),
		.wdata(samp_q),
		.re   (cmd.accept),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign old_sel  = evict_q ? rdata : '0;
	assign fill_new = fill_q + CNT_W'(!evict_q);
	assign var_num  = prod_a_q[VN_W-1:0] - prod_b_q;

	// divider step for the scaled variance
	assign t_v  = {rem_v_q, dq_q[QV_W-1]};
	assign ge_v = (t_v >= (DV_W+1)'(n2_q));

	// divider step for the mean
	assign t_m  = {rem_m_q, mq_q[MEAN_W-1]};
	assign ge_m = (t_m >= (CNT_W+1)'(fill_q));

	// square root step, two radicand bits at a time
	assign t_s     = {rem_s_q, dq_q[QV_W-1:QV_W-2]};
	assign trial_s = (RS_W+2)'({root_q, 2'b01});
	assign ge_s    = (t_s >= trial_s);

	// configuration and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q   <= WINDOW_LENGTH_RST;
			minrdy_q <= MIN_READY_RST;
			wpos_q   <= '0;
			fill_q   <= '0;
			sum_q    <= '0;
			sq_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH: begin
					wlen_q <= cfg_wdata;
					wpos_q <= '0;
					fill_q <= '0;
					sum_q  <= '0;
					sq_q   <= '0;
				end
				REG_MIN_READY: minrdy_q <= cfg_wdata;
				default: ;
			endcase
		end else if (cmd.update) begin
			sum_q  <= sum_q - SUM_W'(old_q) + SUM_W'(samp_q);
			sq_q   <= sq_q - SQ_W'(old_sq_q) + SQ_W'(new_sq_q);
			fill_q <= fill_new;
			if (wpos_q == PTR_W'(MAX_WINDOW - 1)) begin
				wpos_q <= '0;
			end else begin
				wpos_q <= wpos_q + 1'b1;
			end
		end
	end

	// arithmetic working registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			samp_q  <= sample[SAMPLE_BITS-1:0];
			evict_q <= (fill_q >= len_eff);
		end
		if (cmd.square) begin
			old_q    <= old_sel;
			old_sq_q <= old_sel * old_sel;
			new_sq_q <= samp_q * samp_q;
		end
		if (cmd.update) begin
			rdy_q <= (fill_new >= CNT_W'(minrdy_q));
		end
		if (cmd.mult) begin
			prod_a_q <= PA_W'(fill_q) * PA_W'(sq_q);
			prod_b_q <= VN_W'(sum_q) * VN_W'(sum_q);
			n2_q     <= DV_W'(fill_q) * DV_W'(fill_q);
		end

		// shared quotient and radicand shift register
		if (cmd.init) begin
			rem_v_q <= var_num[QV_W-VAR_SHIFT+DV_W-1:QV_W-VAR_SHIFT];
			dq_q    <= {var_num[QV_W-VAR_SHIFT-1:0], {VAR_SHIFT{1'b0}}};
			rem_m_q <= CNT_W'(sum_q[SUM_W-1:SUM_W-MEAN_FRAC]);
			mq_q    <= {sum_q[SUM_W-MEAN_FRAC-1:0], {MEAN_FRAC{1'b0}}};
			rem_s_q <= '0;
			root_q  <= '0;
		end else if (cmd.div_step) begin
			rem_v_q <= ge_v ? DV_W'(t_v - (DV_W+1)'(n2_q)) : DV_W'(t_v);
			dq_q    <= {dq_q[QV_W-2:0], ge_v};
		end else if (cmd.sqrt_step) begin
			rem_s_q <= ge_s ? RS_W'(t_s - trial_s) : RS_W'(t_s);
			root_q  <= {root_q[STD_W-2:0], ge_s};
			dq_q    <= {dq_q[QV_W-3:0], 2'b00};
		end

		// mean divider runs beside the first variance steps
		if (cmd.mean_step) begin
			rem_m_q <= ge_m ? CNT_W'(t_m - (CNT_W+1)'(fill_q)) : CNT_W'(t_m);
			mq_q    <= {mq_q[MEAN_W-2:0], ge_m};
		end

		// result registers
		if (cmd.out_load) begin
			mean_q  <= mq_q;
			std_q   <= root_q;
			ready_q <= rdy_q;
		end
	end

	assign mean_fx   = mean_q;
	assign std_fx    = std_q;
	assign ready_res = ready_q;

endmodule

`default_nettype wire

/* rtl/core/sliding_window_mean_std.sv */
// Top level of the sliding window mean and standard deviation block.
// Depends on swm_pkg, swm_ctrl, swm_dp (and through it swm_ram).
`default_nettype none

// Each accepted sample enters a ring of the last window_length samples (1 to
// 256, a write of window_length empties the window) and updates a running sum
// and sum of squares. One result follows per sample: the mean and the
// population standard deviation, both with 8 fraction bits and rounded down,
// and a flag that is high once the fill count reaches min_ready. After
// acceptance a sample passes through the squares, the sums, the variance
// products and the divider load, then the shift-subtract divider (one
// quotient bit per cycle; the mean divider runs beside it), the square root
// unit (one root bit per cycle) and the load of the result register, which
// waits until any earlier result has been taken. The block then returns to
// idle, in which the next sample is taken. The next sample is taken while a
// finished result still waits on the output. Configuration writes belong to
// idle periods only.
module sliding_window_mean_std
	import swm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [SAMPLE_W-1:0]  sample,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [MEAN_W-1:0]    mean_fx,
	output logic      [STD_W-1:0]     std_fx,
	output logic                      ready_res,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	swm_cmd_t cmd;

	// sequencing controller
	swm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	// datapath
	swm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.sample   (sample),
		.mean_fx  (mean_fx),
		.std_fx   (std_fx),
		.ready_res(ready_res)
	);

endmodule

`default_nettype wire

/* rtl/core/swm_chk.sv */
// Port level checker for sliding_window_mean_std, attached by bind.
// Depends on swm_pkg.
`default_nettype none

module swm_chk
	import swm_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic [MEAN_W-1:0]    mean_fx,
	input wire logic [STD_W-1:0]     std_fx,
	input wire logic                 ready_res
);

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid & in_ready;
	assign out_acc = out_valid & out_ready;

	// requests accepted whose results are not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	// a result never appears without an outstanding request
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pend_q != 2'd0))
		else $error("result shown with no outstanding request");

	// at most one waiting result and one request in work
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two requests outstanding");

	// one request at a time: no accept in the cycle after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input taken again right after a request");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean_fx) && $stable(std_fx)
			&& $stable(ready_res))
		else $error("stalled result changed");

	// standard deviation of 16-bit samples stays within half the range
	a_std_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (std_fx <= 23'd8388480))
		else $error("standard deviation out of range");

endmodule

bind sliding_window_mean_std swm_chk u_swm_chk (.*);

`default_nettype wire

/* verif/tb_sliding_window_mean_std.sv */
// Self-checking testbench for sliding_window_mean_std: random and directed sample streams,
// window and ready-threshold settings, idle bursts on both channels, per-field result checks.
// Depends on swm_pkg and the RTL of the block.
`default_nettype none

module tb_sliding_window_mean_std;
	import swm_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 1250;
	localparam int CALM_FROM    = 1100;

	typedef struct {
		logic [MEAN_W-1:0] mean;
		logic [STD_W-1:0]  sd;
		logic              flag;
	} window_stats_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [SAMPLE_W-1:0]  sample = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [MEAN_W-1:0]    mean_fx;
	logic [STD_W-1:0]     std_fx;
	logic                 ready_res;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_WINDOW_LENGTH;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	// samples waiting to be offered and statistics waiting to come out
	logic [SAMPLE_W-1:0] sample_backlog[$];
	window_stats_t       stats_due[$];

	// shadow of the window: ring, pointers, running sums, registers
	logic [SAMPLE_W-1:0] win_ring [MAX_WINDOW];
	logic [7:0]          wr_ptr;
	logic [8:0]          fill_cnt;
	longint unsigned     sum_acc;
	longint unsigned     sq_acc;
	logic [CFG_W-1:0]    win_len_reg;
	logic [CFG_W-1:0]    min_ready_reg;

	int in_idle_pct = 0;
	int out_idle_pct = 0;
	int in_hold = 0;
	int out_hold = 0;
	int quiet_cycles = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int flags_high = 0;
	int error_count = 0;
	int settings_used = 0;
	int random_items = 0;

	sliding_window_mean_std dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.mean_fx   (mean_fx),
		.std_fx    (std_fx),
		.ready_res (ready_res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_error(input string msg);
		error_count++;
		$display("ERROR: %s", msg);
	endtask

	// window length as the block uses it
	function automatic logic [8:0] eff_window();
		if (win_len_reg == 0)
			return 9'd1;
		if (win_len_reg > MAX_WINDOW)
			return 9'(MAX_WINDOW);
		return win_len_reg;
	endfunction

	// floor of the square root, one root bit at a time from the top
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		int b;
		root = 0;
		for (b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	// evict the oldest sample if full, add the new one, queue the statistics
	task automatic predict_window_stats(input logic [SAMPLE_W-1:0] s_in);
		longint unsigned s, old_v, n, n2, var_num, q, r, scaled;
		logic [7:0] oldest;
		window_stats_t want;
		s = s_in;
		if (fill_cnt >= eff_window() && fill_cnt > 0) begin
			oldest = wr_ptr - fill_cnt[7:0];
			old_v = win_ring[oldest];
			sum_acc -= old_v;
			sq_acc -= old_v * old_v;
			fill_cnt--;
		end
		win_ring[wr_ptr] = s_in;
		wr_ptr++;
		sum_acc += s;
		sq_acc += s * s;
		fill_cnt++;

		n = fill_cnt;
		want.mean = MEAN_W'((sum_acc << MEAN_FRAC) / n);
		var_num = n * sq_acc - sum_acc * sum_acc;
		n2 = n * n;
		q = var_num / n2;
		r = var_num % n2;
		scaled = (q << VAR_SHIFT) + ((r << VAR_SHIFT) / n2);
		want.sd = STD_W'(int_sqrt(scaled));
		want.flag = (fill_cnt >= min_ready_reg);
		stats_due = {stats_due, want};
	endtask

	// length of an idle stretch: with a chance of pct percent a random burst, else none
	function automatic int pick_hold(input int pct);
		if ($urandom_range(0, 99) < pct)
			return $urandom_range(1, 6);
		return 0;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_window_stats(sample);
				samples_sent++;
			end
			if (!in_valid || in_ready) begin
				if (in_hold > 0) begin
					in_hold <= in_hold - 1;
					in_valid <= 1'b0;
				end else if (sample_backlog.size() > 0) begin
					sample <= sample_backlog[0];
					sample_backlog.delete(0);
					in_valid <= 1'b1;
					in_hold <= pick_hold(in_idle_pct);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and output stalls
	always @(posedge clk) begin
		window_stats_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (stats_due.size() == 0) begin
					report_error($sformatf("result %0d arrived with nothing expected",
						results_seen));
				end else begin
					want = stats_due[0];
					stats_due.delete(0);
					if (mean_fx !== want.mean)
						report_error($sformatf("result %0d mean_fx got %0d expected %0d",
							results_seen, mean_fx, want.mean));
					if (std_fx !== want.sd)
						report_error($sformatf("result %0d std_fx got %0d expected %0d",
							results_seen, std_fx, want.sd));
					if (ready_res !== want.flag)
						report_error($sformatf("result %0d ready_res got %b expected %b",
							results_seen, ready_res, want.flag));
					if (want.flag)
						flags_high++;
				end
				results_seen++;
			end
			if (out_hold > 0) begin
				out_hold <= out_hold - 1;
				out_ready <= 1'b0;
			end else if (out_ready && $urandom_range(0, 99) < out_idle_pct) begin
				out_hold <= $urandom_range(1, 6) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
			$display("tb_sliding_window_mean_std failed");
			$finish;
		end
	end

	// wait until nothing is queued, offered or outstanding
	task automatic wait_idle();
		@(negedge clk);
		while (sample_backlog.size() != 0 || in_valid || stats_due.size() != 0)
			@(negedge clk);
	endtask

	// one register write; a window length write empties the window
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WINDOW_LENGTH) begin
			win_len_reg = val;
			wr_ptr = '0;
			fill_cnt = '0;
			sum_acc = 0;
			sq_acc = 0;
		end else if (idx == REG_MIN_READY) begin
			min_ready_reg = val;
		end
		@(negedge clk);
	endtask

	function automatic int pick_rate();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 25;
			2: return 60;
			default: return 85;
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] any_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return SAMPLE_W'($urandom_range(0, 15));
			3: return SAMPLE_W'(16'hFFFF - $urandom_range(0, 15));
			default: return SAMPLE_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// mostly short windows, now and then out of range or the full ring
	function automatic logic [CFG_W-1:0] pick_window();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return CFG_W'($urandom_range(257, 511));
		if (r == 2)
			return CFG_W'(MAX_WINDOW);
		if (r < 12)
			return CFG_W'($urandom_range(1, 8));
		if (r < 17)
			return CFG_W'($urandom_range(9, 40));
		return CFG_W'($urandom_range(41, 255));
	endfunction

	task automatic random_phase(input bit calm);
		logic [CFG_W-1:0] min_val;
		int eff;
		int count;
		int pick;
		wait_idle();
		in_idle_pct = calm ? 0 : pick_rate();
		out_idle_pct = calm ? 0 : pick_rate();
		// keep the window running now and then, only moving the threshold
		if ($urandom_range(0, 9) < 6)
			write_reg(REG_WINDOW_LENGTH, pick_window());
		eff = eff_window();
		pick = $urandom_range(0, 9);
		if (pick == 0)
			min_val = '0;
		else if (pick == 1)
			min_val = '1;
		else if (pick == 2)
			min_val = CFG_W'(MAX_WINDOW);
		else
			min_val = CFG_W'($urandom_range(0, eff + 2));
		write_reg(REG_MIN_READY, min_val);
		settings_used++;
		count = eff * 2 + $urandom_range(1, 16);
		if (count > 90)
			count = $urandom_range(40, 90);
		repeat (count)
			sample_backlog = {sample_backlog, any_sample()};
		random_items += count;
	endtask

	// stimulus
	initial begin
		win_len_reg = WINDOW_LENGTH_RST;
		min_ready_reg = MIN_READY_RST;
		wr_ptr = '0;
		fill_cnt = '0;
		sum_acc = 0;
		sq_acc = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, extremes of the sample
		in_idle_pct = 25;
		out_idle_pct = 25;
		@(negedge clk);
		sample_backlog = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001};
		settings_used++;

		// zero window length clamps to one
		wait_idle();
		write_reg(REG_WINDOW_LENGTH, 9'd0);
		write_reg(REG_MIN_READY, 9'd2);
		sample_backlog = '{16'hFFFF, 16'h0000, 16'h3039};
		settings_used++;

		// oversized window length clamps to the full ring, threshold zero
		wait_idle();
		write_reg(REG_WINDOW_LENGTH, 9'd511);
		write_reg(REG_MIN_READY, 9'd0);
		sample_backlog = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000};
		settings_used++;

		// threshold change alone leaves the window as it is
		wait_idle();
		write_reg(REG_MIN_READY, 9'd9);
		sample_backlog = '{16'h0001, 16'h0002, 16'h8000};
		settings_used++;

		// two-sample window, threshold never reached
		wait_idle();
		write_reg(REG_WINDOW_LENGTH, 9'd2);
		write_reg(REG_MIN_READY, 9'd256);
		sample_backlog = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h7FFF};
		settings_used++;

		// full ring of extremes, long enough to evict and wrap the pointer
		wait_idle();
		in_idle_pct = pick_rate();
		out_idle_pct = pick_rate();
		write_reg(REG_WINDOW_LENGTH, 9'd256);
		write_reg(REG_MIN_READY, 9'd200);
		settings_used++;
		repeat (300)
			sample_backlog = {sample_backlog, (($urandom_range(0, 3) != 0) ?
				($urandom_range(0, 1) ? 16'hFFFF : 16'h0000) : any_sample())};
		random_items += 300;

		while (random_items < RANDOM_ITEMS)
			random_phase(random_items >= CALM_FROM);

		wait_idle();
		repeat (100) @(posedge clk);
		if (stats_due.size() != 0)
			report_error($sformatf("%0d results never arrived", stats_due.size()));
		$display("ran %0d samples through %0d window and threshold settings", samples_sent,
			settings_used);
		$display("checked %0d results, %0d of them with the ready flag set, %0d errors",
			results_seen, flags_high, error_count);
		if (error_count == 0)
			$display("tb_sliding_window_mean_std passed");
		else
			$display("tb_sliding_window_mean_std failed");
		$finish;
	end

endmodule

`default_nettype wire
